[design/rat_pkg.sv]
// Shared types and constants for the region address translator.
package rat_pkg;

   // Table geometry
   localparam int TABLE_ENTRIES = 16;
   localparam int ENTRY_IDX_W   = 4;
   localparam int COUNT_W       = 5;

   // Field widths
   localparam int ADDR_W      = 64;
   localparam int PAGES_W     = 32;
   localparam int FRAME_W     = 32;
   localparam int PAGE_SIZE_W = 21;
   localparam int PROD_W      = PAGES_W + PAGE_SIZE_W;

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAGE_SIZE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENTRY_COUNT = 2'd1;
   localparam logic [PAGE_SIZE_W-1:0] PAGE_SIZE_RESET = 21'd8192;
   localparam logic [COUNT_W-1:0]     ENTRY_COUNT_RESET = 5'd0;

   // Request opcodes
   localparam logic OP_WRITE     = 1'b0;
   localparam logic OP_TRANSLATE = 1'b1;

   typedef struct packed {
      logic                   opcode;
      logic [ENTRY_IDX_W-1:0] entry_index;
      logic [ADDR_W-1:0]      region_start;
      logic [PAGES_W-1:0]     region_pages;
      logic [FRAME_W-1:0]     region_frame;
      logic [ADDR_W-1:0]      virtual_address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] physical_address;
      logic              hit;
   } rsp_type;

   // Broadcast table write to all cells
   typedef struct packed {
      logic                   en;
      logic [ENTRY_IDX_W-1:0] slot;
      logic [ADDR_W-1:0]      start;
      logic [PAGES_W-1:0]     pages;
      logic [FRAME_W-1:0]     frame;
   } wr_type;

   // Lookup token handed from cell to cell
   typedef struct packed {
      logic              valid;
      logic              found;
      logic [ADDR_W-1:0] va;
      logic [ADDR_W-1:0] pa;
   } probe_type;

endpackage

[design/rat_cell.sv]
// One table cell: holds a region, checks the passing lookup and forwards it.
module rat_cell
   import rat_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic [ENTRY_IDX_W-1:0] cell_index,
   input  logic [PAGE_SIZE_W-1:0] page_size,
   input  logic [COUNT_W-1:0]     entry_count,
   input  wr_type                 wr,
   input  probe_type              probe_in,
   output probe_type              probe_out
);

   logic [ADDR_W-1:0]  start_ff;
   logic [PAGES_W-1:0] pages_ff;
   logic [FRAME_W-1:0] frame_ff;
   logic [PROD_W-1:0]  len_ff, len_in;
   logic [PROD_W-1:0]  base_ff, base_in;
   probe_type          probe_ff, probe_in_next;

   logic              active;
   logic              in_range;
   logic              take;
   logic [ADDR_W-1:0] offset;

   // Region storage, loaded by a write request aimed at this slot
   always_ff @(posedge clock) begin
      if (wr.en && (wr.slot == cell_index)) begin
         start_ff <= wr.start;
         pages_ff <= wr.pages;
         frame_ff <= wr.frame;
      end
   end

   // Region length and base in bytes, kept current from the stored entry
   assign len_in  = PROD_W'(pages_ff) * PROD_W'(page_size);
   assign base_in = PROD_W'(frame_ff) * PROD_W'(page_size);

   always_ff @(posedge clock) begin
      len_ff  <= len_in;
      base_ff <= base_in;
   end

   // Range check against the passing lookup
   assign active   = {1'b0, cell_index} < entry_count;
   assign offset   = probe_in.va - start_ff;
   assign in_range = (probe_in.va >= start_ff) &&
                     (offset < ADDR_W'(len_ff));
   assign take     = probe_in.valid && !probe_in.found && active && in_range;

   always_comb begin
      probe_in_next       = probe_in;
      probe_in_next.found = probe_in.found | take;
      if (take) begin
         probe_in_next.pa = ADDR_W'(base_ff) + offset;
      end
   end

   // Hand the token to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff.valid <= 1'b0;
      end else begin
         probe_ff.valid <= probe_in_next.valid;
      end
      probe_ff.found <= probe_in_next.found;
      probe_ff.va    <= probe_in_next.va;
      probe_ff.pa    <= probe_in_next.pa;
   end

   assign probe_out = probe_ff;

   // A hit found upstream is never lost
   a_found_kept: assert property (@(posedge clock) disable iff (reset)
      probe_in.valid && probe_in.found |=> probe_out.found &&
         probe_out.pa == $past(probe_in.pa))
      else $error("rat_cell: earlier hit overwritten");

   // An inactive cell never claims the lookup
   a_inactive_pass: assert property (@(posedge clock) disable iff (reset)
      probe_in.valid && !probe_in.found && !active |=> !probe_out.found)
      else $error("rat_cell: inactive cell produced a hit");

   // The token moves one cell per cycle
   a_token_moves: assert property (@(posedge clock) disable iff (reset)
      probe_in.valid |=> probe_out.valid)
      else $error("rat_cell: lookup token dropped");

endmodule

[design/region_address_translator_top.sv]
// Top level of the region address translator: config, cell chain, response.
//
// A write request loads one table slot and holds off the next request while
// the settle register is set. A translate request walks the chain of
// TABLE_ENTRIES (16) cells, one cell per cycle; its result passes the 16
// cell stages, the first loaded at the accepting edge, then one result stage
// and the response register. One translate is in flight at a time; the next
// request may be accepted while the previous response still waits on
// rsp_ready. A configuration write also holds off the next request while
// the cells update their region lengths. The latency grows with the length
// of the cell chain.
module region_address_translator_top
   import rat_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic [PAGE_SIZE_W-1:0] page_size_ff, page_size_in;
   logic [COUNT_W-1:0]     entry_count_ff, entry_count_in;
   logic                   busy_ff, busy_in;
   logic                   settle_ff, settle_in;
   logic                   done_valid_ff, done_valid_in;
   rsp_type                done_data_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff;

   logic                   req_accept;
   logic                   csr_accept;
   logic                   done_move;
   wr_type                 wr;
   probe_type              probe_bus [0:TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] chain_valid;

   assign csr_ready  = 1'b1;
   assign csr_accept = csr_valid && csr_ready;
   assign req_ready  = !busy_ff && !settle_ff;
   assign req_accept = req_valid && req_ready;

   // Configuration registers
   always_comb begin
      page_size_in   = page_size_ff;
      entry_count_in = entry_count_ff;
      if (csr_accept) begin
         case (csr_index)
            CSR_PAGE_SIZE:   page_size_in   = csr_data[PAGE_SIZE_W-1:0];
            CSR_ENTRY_COUNT: entry_count_in = csr_data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_size_ff   <= PAGE_SIZE_RESET;
         entry_count_ff <= ENTRY_COUNT_RESET;
      end else begin
         page_size_ff   <= page_size_in;
         entry_count_ff <= entry_count_in;
      end
   end

   // Table write broadcast
   always_comb begin
      wr.en    = req_accept && (req_data.opcode == OP_WRITE);
      wr.slot  = req_data.entry_index;
      wr.start = req_data.region_start;
      wr.pages = req_data.region_pages;
      wr.frame = req_data.region_frame;
   end

   // Lookup token entering the chain
   always_comb begin
      probe_bus[0].valid = req_accept && (req_data.opcode == OP_TRANSLATE);
      probe_bus[0].found = 1'b0;
      probe_bus[0].va    = req_data.virtual_address;
      probe_bus[0].pa    = '1;
   end

   // Chain of cells
   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      rat_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cell_index  (ENTRY_IDX_W'(i)),
         .page_size   (page_size_ff),
         .entry_count (entry_count_ff),
         .wr          (wr),
         .probe_in    (probe_bus[i]),
         .probe_out   (probe_bus[i+1])
      );
      assign chain_valid[i] = probe_bus[i+1].valid;
   end

   // Result stage and response register
   assign done_move = done_valid_ff && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      done_valid_in = done_valid_ff;
      if (probe_bus[TABLE_ENTRIES].valid) begin
         done_valid_in = 1'b1;
      end else if (done_move) begin
         done_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (done_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      busy_in = busy_ff;
      if (probe_bus[0].valid) begin
         busy_in = 1'b1;
      end else if (done_move) begin
         busy_in = 1'b0;
      end

      settle_in = csr_accept || wr.en;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         busy_ff       <= 1'b0;
         settle_ff     <= 1'b0;
      end else begin
         done_valid_ff <= done_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         busy_ff       <= busy_in;
         settle_ff     <= settle_in;
      end
   end

   always_ff @(posedge clock) begin
      if (probe_bus[TABLE_ENTRIES].valid) begin
         done_data_ff.physical_address <= probe_bus[TABLE_ENTRIES].pa;
         done_data_ff.hit              <= probe_bus[TABLE_ENTRIES].found;
      end
      if (done_move) begin
         rsp_data_ff <= done_data_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // At most one lookup in the chain
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $countones(chain_valid) <= 1)
      else $error("rat_top: more than one lookup in the chain");

   // A pending result always belongs to the request in flight
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      done_valid_ff |-> busy_ff)
      else $error("rat_top: result pending while idle");

   // A lookup in the chain keeps new requests out
   a_chain_blocks: assert property (@(posedge clock) disable iff (reset)
      (chain_valid != '0) |-> !req_ready)
      else $error("rat_top: request accepted during lookup");

   // A miss always reports all ones
   a_miss_ones: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.hit |-> rsp_data_ff.physical_address == '1)
      else $error("rat_top: miss without all-ones address");

endmodule
